>>> hdl/dhpt_pkg.sv
package dhpt_pkg;

    localparam int TS_W = 7;
    localparam logic [TS_W-1:0] TS_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NO_FREE  = 3'd4,
        ST_ABSENT   = 3'd5
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

endpackage

>>> hdl/dhpt_ram.sv
module dhpt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

>>> hdl/dhpt_front.sv
module dhpt_front #(
    parameter int SLOTS      = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             action,
    input  logic signed [COORD_BITS-1:0]     coord_a,
    input  logic signed [COORD_BITS-1:0]     coord_b,
    input  logic signed [COORD_BITS-1:0]     coord_c,
    input  logic [$clog2(SLOTS+1)-1:0]       ets,
    output logic                             q_push,
    input  logic                             q_full,
    output logic [1+3*COORD_BITS+2*$clog2(SLOTS)-1:0] q_data
);
    import dhpt_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int H1_W   = CW + 2;
    localparam int SQ_W   = 2*CW + 2;
    localparam int RT_W   = CW + 1;
    localparam int T3_W   = 2*RT_W + 2;
    localparam int STEP_W = $clog2(SQ_W+1);

    typedef enum logic [4:0] {
        F_IDLE   = 5'b00001,
        F_SQUARE = 5'b00010,
        F_ROOT   = 5'b00100,
        F_MOD    = 5'b01000,
        F_SEND   = 5'b10000
    } fstate_t;

    fstate_t                state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   act_reg;
    logic [CW-1:0]          a_reg, b_reg, c_reg;
    logic [H1_W-1:0]        h1_reg, h1_next;
    logic [H1_W-1:0]        h2_reg, h2_next;
    logic [SQ_W-1:0]        x_reg, x_next;
    logic [RT_W-1:0]        root_reg, root_next;
    logic [RT_W-1:0]        bit_reg, bit_next;
    logic [SLOT_W-1:0]      m1_reg, m1_next, m2_reg, m2_next;

    logic signed [CW-1:0]   sq_op;
    logic signed [2*CW-1:0] sq_prod;
    logic signed [H1_W-1:0] sum;
    logic [RT_W-1:0]        root_try;
    logic [2*RT_W-1:0]      root_sq;
    logic [T3_W-1:0]        root_sq3;
    logic [SLOT_W:0]        mr1, mr2, ets_x;

    assign full  = (state_reg != F_IDLE);
    assign ets_x = (SLOT_W+1)'(ets);

    // The root is the largest value whose square, taken three times, does not exceed the
    // sum of squares; it is built one bit at a time from the top.
    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    sq_op = $signed(a_reg);
            2'd1:    sq_op = $signed(b_reg);
            default: sq_op = $signed(c_reg);
        endcase
        sq_prod  = sq_op * sq_op;
        sum      = H1_W'(coord_a) + H1_W'(coord_b) + H1_W'(coord_c);
        root_try = root_reg | bit_reg;
        root_sq  = root_try * root_try;
        root_sq3 = T3_W'({root_sq, 1'b0}) + T3_W'(root_sq);
        mr1 = {m1_reg, h1_reg[H1_W-1]};
        mr2 = {m2_reg, h2_reg[H1_W-1]};
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        x_next     = x_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    h1_next    = sum[H1_W-1] ? H1_W'(-sum) : H1_W'(sum);
                    x_next     = '0;
                    step_next  = '0;
                    state_next = F_SQUARE;
                end
            end
            F_SQUARE:
            begin
                x_next = x_reg + SQ_W'($unsigned(sq_prod));
                if (step_reg == STEP_W'(2))
                begin
                    step_next  = '0;
                    root_next  = '0;
                    bit_next   = {1'b1, {(RT_W-1){1'b0}}};
                    state_next = F_ROOT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            F_ROOT:
            begin
                if (root_sq3 <= T3_W'(x_reg))
                begin
                    root_next = root_try;
                end
                bit_next = bit_reg >> 1;
                if (bit_reg[0])
                begin
                    step_next  = '0;
                    h2_next    = H1_W'(root_next);
                    m1_next    = '0;
                    m2_next    = '0;
                    state_next = F_MOD;
                end
            end
            F_MOD:
            begin
                h1_next = {h1_reg[H1_W-2:0], 1'b0};
                h2_next = {h2_reg[H1_W-2:0], 1'b0};
                m1_next = (mr1 >= ets_x) ? SLOT_W'(mr1 - ets_x) : SLOT_W'(mr1);
                m2_next = (mr2 >= ets_x) ? SLOT_W'(mr2 - ets_x) : SLOT_W'(mr2);
                if (step_reg == STEP_W'(H1_W-1))
                begin
                    state_next = F_SEND;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            F_SEND:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_data = {act_reg, a_reg, b_reg, c_reg, m1_reg, m2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            act_reg <= action;
            a_reg   <= coord_a;
            b_reg   <= coord_b;
            c_reg   <= coord_c;
        end
        step_reg <= step_next;
        h1_reg   <= h1_next;
        h2_reg   <= h2_next;
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
    end

endmodule

>>> hdl/dhpt_queue.sv
module dhpt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    output logic             q_full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd,
    output logic             q_valid,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign rdata   = data_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd)
            begin
                rp_reg <= ~rp_reg;
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            data_reg[wp_reg] <= wdata;
        end
    end

endmodule

>>> hdl/dhpt_back.sv
module dhpt_back #(
    parameter int SLOTS      = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  logic [1+3*COORD_BITS+2*$clog2(SLOTS)-1:0] q_data,
    input  logic [$clog2(SLOTS+1)-1:0]       ets,
    output logic                             empty,
    input  logic                             pop,
    output dhpt_pkg::status_t                status,
    output logic [$clog2(SLOTS)-1:0]         slot,
    output logic [$clog2(SLOTS+1)-1:0]       count_after
);
    import dhpt_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS+1);
    localparam int KEY_W  = 3*COORD_BITS;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_PROBE = 4'b0010,
        B_CMP   = 4'b0100,
        B_REPLY = 4'b1000
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [SLOTS-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   probe_reg, probe_next;
    logic [SLOT_W-1:0]  p_reg, p_next;
    logic [SLOT_W-1:0]  h2_reg, h2_next;
    logic               act_reg, act_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    status_t            st_reg, st_next;
    logic [SLOT_W-1:0]  rslot_reg, rslot_next;
    logic               res_valid_reg;
    status_t            res_status_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [CNT_W-1:0]   res_count_reg;

    logic               ram_we;
    logic [KEY_W-1:0]   ram_rdata;
    logic [SLOT_W:0]    step_sum, first_sum, ets_x;
    logic [SLOT_W-1:0]  p_step, p_first;
    logic               q_act;
    logic [KEY_W-1:0]   q_key;
    logic [SLOT_W-1:0]  q_h1, q_h2;
    logic               can_reply;

    dhpt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .addr  (p_reg),
        .wdata (key_reg),
        .rdata (ram_rdata)
    );

    assign {q_act, q_key, q_h1, q_h2} = q_data;
    assign ets_x     = (SLOT_W+1)'(ets);
    assign step_sum  = (SLOT_W+1)'(p_reg) + (SLOT_W+1)'(h2_reg);
    assign p_step    = (step_sum >= ets_x) ? SLOT_W'(step_sum - ets_x) : SLOT_W'(step_sum);
    assign first_sum = (SLOT_W+1)'(q_h1) + (SLOT_W+1)'(q_h2);
    assign p_first   = (first_sum >= ets_x) ? SLOT_W'(first_sum - ets_x)
                                            : SLOT_W'(first_sum);
    assign can_reply = !res_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        count_next = count_reg;
        probe_next = probe_reg;
        p_next     = p_reg;
        h2_next    = h2_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        st_next    = st_reg;
        rslot_next = rslot_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    act_next   = q_act;
                    key_next   = q_key;
                    h2_next    = q_h2;
                    p_next     = p_first;
                    probe_next = CNT_W'(1);
                    rslot_next = '0;
                    if (q_act == ACT_INSERT && count_reg >= ets)
                    begin
                        st_next    = ST_FULL;
                        state_next = B_REPLY;
                    end
                    else if (q_act == ACT_REMOVE && count_reg == '0)
                    begin
                        st_next    = ST_EMPTY;
                        state_next = B_REPLY;
                    end
                    else
                    begin
                        state_next = B_PROBE;
                    end
                end
            end
            B_PROBE, B_CMP:
            begin
                if (state_reg == B_PROBE && act_reg == ACT_INSERT && !occ_reg[p_reg])
                begin
                    ram_we          = 1'b1;
                    occ_next[p_reg] = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    st_next         = ST_INSERTED;
                    rslot_next      = p_reg;
                    state_next      = B_REPLY;
                end
                else if (state_reg == B_PROBE && act_reg == ACT_REMOVE && occ_reg[p_reg])
                begin
                    state_next = B_CMP;
                end
                else if (state_reg == B_CMP && ram_rdata == key_reg)
                begin
                    occ_next[p_reg] = 1'b0;
                    count_next      = count_reg - CNT_W'(1);
                    st_next         = ST_REMOVED;
                    rslot_next      = p_reg;
                    state_next      = B_REPLY;
                end
                else if (probe_reg == ets)
                begin
                    st_next    = (act_reg == ACT_INSERT) ? ST_NO_FREE : ST_ABSENT;
                    state_next = B_REPLY;
                end
                else
                begin
                    probe_next = probe_reg + CNT_W'(1);
                    p_next     = p_step;
                    state_next = B_PROBE;
                end
            end
            B_REPLY:
            begin
                if (can_reply)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign empty       = !res_valid_reg;
    assign status      = res_status_reg;
    assign slot        = res_slot_reg;
    assign count_after = res_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            occ_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            count_reg <= count_next;
            if (state_reg == B_REPLY && can_reply)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        p_reg     <= p_next;
        h2_reg    <= h2_next;
        act_reg   <= act_next;
        key_reg   <= key_next;
        st_reg    <= st_next;
        rslot_reg <= rslot_next;
        if (state_reg == B_REPLY && can_reply)
        begin
            res_status_reg <= st_reg;
            res_slot_reg   <= rslot_reg;
            res_count_reg  <= count_reg;
        end
    end

endmodule

>>> hdl/double_hash_point_table_unit.sv
// Open-addressing table of three-dimensional points with double hashing. Each request passes
// through the hash unit (three squares on one multiplier, a square root built one bit per
// cycle by testing three times the square of each trial value against the sum of squares,
// and a bit-serial reduction by the table size), then through the prober, which takes the
// request, spends one probe step per probe for an insert and adds a compare step for an
// occupied slot on a remove, as the key memory has a single port with a registered read,
// and then hands over the result; a two-entry queue lets the hash unit work on the next
// request while the prober is busy. The result stays on the output until popped, and
// table_size may only be written while the block is idle.
module double_hash_point_table_unit #(
    parameter int SLOTS      = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic                         action,
    input  logic signed [COORD_BITS-1:0] coord_a,
    input  logic signed [COORD_BITS-1:0] coord_b,
    input  logic signed [COORD_BITS-1:0] coord_c,
    output logic                         empty,
    input  logic                         pop,
    output dhpt_pkg::status_t            status,
    output logic [$clog2(SLOTS)-1:0]     slot,
    output logic [$clog2(SLOTS+1)-1:0]   count_after
);
    import dhpt_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS+1);
    localparam int QW     = 1 + 3*COORD_BITS + 2*SLOT_W;
    localparam int EW     = CNT_W + TS_W;

    logic [TS_W-1:0]  ts_reg;
    logic [CNT_W-1:0] ets;
    logic [EW-1:0]    ts_wide;
    logic             q_push, q_full, q_pop, q_valid;
    logic [QW-1:0]    q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == 1'b0) ? 32'(ts_reg) : 32'd0;
    assign ts_wide = EW'(ts_reg);

    always_comb
    begin
        if (ts_reg == '0)
        begin
            ets = CNT_W'(1);
        end
        else if (ts_wide > EW'(SLOTS))
        begin
            ets = CNT_W'(SLOTS);
        end
        else
        begin
            ets = CNT_W'(ts_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= TS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            ts_reg <= pwdata[TS_W-1:0];
        end
    end

    dhpt_front #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .action  (action),
        .coord_a (coord_a),
        .coord_b (coord_b),
        .coord_c (coord_c),
        .ets     (ets),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_data  (q_wdata)
    );

    dhpt_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .q_full  (q_full),
        .wdata   (q_wdata),
        .rd      (q_pop),
        .q_valid (q_valid),
        .rdata   (q_rdata)
    );

    dhpt_back #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_rdata),
        .ets         (ets),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .slot        (slot),
        .count_after (count_after)
    );

endmodule

>>> tb/double_hash_point_table_unit_tb.sv
`timescale 1ns / 100ps

module double_hash_point_table_unit_tb;
    import dhpt_pkg::*;

    localparam int SLOTS = 64;
    localparam int CB = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [2:0] ADDR_TABLE_SIZE = 3'd0;

    typedef struct {
        action_t          act;
        logic signed [CB-1:0] a;
        logic signed [CB-1:0] b;
        logic signed [CB-1:0] c;
    } point_req_t;

    typedef struct {
        status_t    st;
        logic [5:0] slot;
        logic [6:0] cnt;
    } outcome_t;

    typedef struct {
        point_req_t req;
        bit         known;
        outcome_t   want;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic push;
    logic full;
    action_t action;
    logic signed [CB-1:0] coord_a;
    logic signed [CB-1:0] coord_b;
    logic signed [CB-1:0] coord_c;
    logic empty;
    logic pop;
    status_t status;
    logic [5:0] slot;
    logic [6:0] count_after;

    double_hash_point_table_unit #(.SLOTS(SLOTS), .COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .action(action),
        .coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c),
        .empty(empty), .pop(pop), .status(status), .slot(slot),
        .count_after(count_after)
    );

    // Shadow of the table, updated as each request is accepted.
    logic [3*CB-1:0] shadow_keys [SLOTS];
    bit shadow_occ [SLOTS];
    int unsigned shadow_count;
    logic [6:0] shadow_size;

    outcome_t outcome_q[$];
    outcome_t known_q[$];
    bit known_flag_q[$];
    logic [3*CB-1:0] key_pool[$];
    int errors;
    int checked;
    int burst_left;
    int gap_max;
    int insert_pct;
    longint unsigned cycles;

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic outcome_t apply_request(input point_req_t r);
        outcome_t o;
        longint sa;
        longint sb;
        longint sc;
        longint sum;
        longint unsigned h1;
        longint unsigned h2;
        longint unsigned ts;
        longint unsigned p;
        logic [3*CB-1:0] key;
        sa = r.a;
        sb = r.b;
        sc = r.c;
        sum = sa + sb + sc;
        h1 = (sum < 0) ? -sum : sum;
        h2 = int_sqrt(longint'(sa * sa + sb * sb + sc * sc) / 3);
        ts = (shadow_size < 1) ? 1 : ((shadow_size > SLOTS) ? SLOTS : shadow_size);
        key = {r.a, r.b, r.c};
        o.slot = '0;
        if (r.act == ACT_INSERT)
        begin
            if (shadow_count >= ts)
                o.st = ST_FULL;
            else
            begin
                o.st = ST_NO_FREE;
                for (int i = 1; i <= ts; i++)
                begin
                    p = (h1 + i * h2) % ts;
                    if (!shadow_occ[p])
                    begin
                        shadow_keys[p] = key;
                        shadow_occ[p] = 1;
                        shadow_count++;
                        o.st = ST_INSERTED;
                        o.slot = 6'(p);
                        break;
                    end
                end
            end
        end
        else
        begin
            if (shadow_count == 0)
                o.st = ST_EMPTY;
            else
            begin
                o.st = ST_ABSENT;
                for (int i = 1; i <= ts; i++)
                begin
                    p = (h1 + i * h2) % ts;
                    if (shadow_occ[p] && shadow_keys[p] == key)
                    begin
                        shadow_occ[p] = 0;
                        shadow_count--;
                        o.st = ST_REMOVED;
                        o.slot = 6'(p);
                        break;
                    end
                end
            end
        end
        o.cnt = 7'(shadow_count);
        return o;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Accepted requests are predicted at the edge that takes them.
    always @(posedge clk)
    begin
        point_req_t r;
        outcome_t o;
        if (rst_n && push && !full)
        begin
            r.act = action;
            r.a = coord_a;
            r.b = coord_b;
            r.c = coord_c;
            o = apply_request(r);
            if (known_flag_q.size() > 0 && known_flag_q.pop_front())
            begin
                if (known_q[0].st != o.st || known_q[0].slot != o.slot ||
                    known_q[0].cnt != o.cnt)
                begin
                    $display("%0t: predictor disagrees with table: expected %p, predicted %p",
                             $time, known_q[0], o);
                    errors++;
                end
                o = known_q.pop_front();
            end
            outcome_q.push_back(o);
            if (r.act == ACT_INSERT && o.st == ST_INSERTED)
            begin
                key_pool.push_back({r.a, r.b, r.c});
                if (key_pool.size() > 80)
                    void'(key_pool.pop_front());
            end
        end
    end

    // Result side: checks and a stall pattern, with one long hold-off.
    always @(posedge clk)
    begin
        outcome_t w;
        int hold;
        int mode;
        bit held;
        if (rst_n && pop && !empty)
        begin
            checked++;
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d slot=%0d count=%0d",
                         $time, status, slot, count_after);
                errors++;
            end
            else
            begin
                w = outcome_q.pop_front();
                if (status !== w.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, w.st, status);
                    errors++;
                end
                if (slot !== w.slot)
                begin
                    $display("%0t: slot expected %0d actual %0d", $time, w.slot, slot);
                    errors++;
                end
                if (count_after !== w.cnt)
                begin
                    $display("%0t: count_after expected %0d actual %0d",
                             $time, w.cnt, count_after);
                    errors++;
                end
            end
        end
        if (checked == 400 && !held)
        begin
            held = 1;
            hold = 3000;
        end
        if (cycles % 300 == 0)
            mode = $urandom_range(0, 2);
        if (hold > 0)
        begin
            hold--;
            pop <= 1'b0;
        end
        else if (mode == 0)
            pop <= 1'b1;
        else if (mode == 1)
            pop <= $urandom_range(0, 1);
        else
            pop <= ($urandom_range(0, 4) == 0);
    end

    task automatic offer(input point_req_t r);
        int gap;
        push <= 1'b1;
        action <= r.act;
        coord_a <= r.a;
        coord_b <= r.b;
        coord_c <= r.c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 3) == 0)
                gap_max = 0;
            else
                gap_max = $urandom_range(1, 60);
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic set_table_size(input logic [6:0] v);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TABLE_SIZE;
        pwdata <= {25'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        shadow_size = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[6:0] !== v)
        begin
            $display("%0t: table_size read expected %0d actual %0d", $time, v, prdata[6:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [CB-1:0] pick_coord(input int style);
        case (style)
            0: return CB'($urandom);
            1: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
            default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic point_req_t random_request();
        point_req_t r;
        int style;
        r.act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
        if (key_pool.size() > 0 && $urandom_range(0, 99) < 55)
            {r.a, r.b, r.c} = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
        begin
            style = $urandom_range(0, 9);
            style = (style < 4) ? 0 : ((style < 9) ? 1 : 2);
            r.a = pick_coord(style);
            r.b = pick_coord(style);
            r.c = pick_coord(style);
        end
        return r;
    endfunction

    directed_row_t rows[$];
    logic [6:0] sizes[$];

    function automatic directed_row_t row(input action_t act, input int a, input int b,
                                          input int c, input bit known, input status_t st,
                                          input int s, input int n);
        directed_row_t d;
        d.req.act = act;
        d.req.a = CB'(a);
        d.req.b = CB'(b);
        d.req.c = CB'(c);
        d.known = known;
        d.want.st = st;
        d.want.slot = 6'(s);
        d.want.cnt = 7'(n);
        return d;
    endfunction

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        push = 0;
        pop = 0;
        action = ACT_INSERT;
        coord_a = '0;
        coord_b = '0;
        coord_c = '0;
        errors = 0;
        checked = 0;
        cycles = 0;
        burst_left = 5;
        gap_max = 10;
        shadow_size = TS_RESET;
        shadow_count = 0;
        foreach (shadow_occ[i])
            shadow_occ[i] = 0;

        rows.push_back(row(ACT_REMOVE, 1, 2, 3, 1, ST_EMPTY, 0, 0));
        rows.push_back(row(ACT_INSERT, 0, 0, 0, 1, ST_INSERTED, 0, 1));
        rows.push_back(row(ACT_REMOVE, 0, 0, 0, 1, ST_REMOVED, 0, 0));
        rows.push_back(row(ACT_INSERT, 32767, 32767, 32767, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_INSERT, -32768, -32768, -32768, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_INSERT, -32768, 32767, 0, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_INSERT, 0, 0, 0, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_INSERT, 0, 0, 0, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_INSERT, 1, -1, 0, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_INSERT, 1, -1, 0, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_REMOVE, 5, 5, 5, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_REMOVE, 32767, 32767, 32767, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_REMOVE, -32768, -32768, -32768, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_REMOVE, 1, -1, 0, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_REMOVE, 1, -1, 0, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_REMOVE, 1, -1, 0, 0, ST_INSERTED, 0, 0));
        rows.push_back(row(ACT_INSERT, -1, -2, 3, 0, ST_INSERTED, 0, 0));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            known_flag_q.push_back(rows[i].known);
            if (rows[i].known)
                known_q.push_back(rows[i].want);
            offer(rows[i].req);
        end

        // A size of one with zero-hash keys and a small size give full and no-free cases;
        // the drop from 64 to 8 leaves entries beyond the probed range.
        sizes = '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127, 7'd5, 7'd64, 7'd8, 7'd13, 7'd33, 7'd64};
        foreach (sizes[p])
        begin
            if (p != 0)
                set_table_size(sizes[p]);
            insert_pct = (p % 3 == 0) ? 75 : ((p % 3 == 1) ? 50 : 35);
            repeat (170)
            begin
                known_flag_q.push_back(0);
                offer(random_request());
            end
        end

        push <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hdl/dhpt_pkg.sv
hdl/dhpt_ram.sv
hdl/dhpt_front.sv
hdl/dhpt_queue.sv
hdl/dhpt_back.sv
hdl/double_hash_point_table_unit.sv
tb/double_hash_point_table_unit_tb.sv
